// File: sv/htu_pkg.sv
// Package with shared constants, command codes and helpers for the transform unit.
`default_nettype none
package htu_pkg;
   localparam int DIM_DEFAULT = 4;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int WORD_W = 32;
   localparam int KIND_W = 3;
   localparam int ATAN_ENTRIES = 24;
   localparam logic [31:0] CORDIC_GAIN_Q30 = 32'h26DD3B6A;
   localparam logic [31:0] DEG_TO_TURN = 32'd3054198966;
   localparam logic [31:0] RAD_TO_TURN = 32'd2734261102;

   typedef enum logic [KIND_W-1:0] {
      KIND_IDENTITY  = 3'd0,
      KIND_TRANSPOSE = 3'd1,
      KIND_TRANSLATE = 3'd2,
      KIND_SCALE     = 3'd3,
      KIND_ROT_DEG   = 3'd4,
      KIND_ROT_RAD   = 3'd5,
      KIND_VECTOR    = 3'd6,
      KIND_UNUSED    = 3'd7
   } kind_type;

   typedef struct packed {
      logic start;
      logic [31:0] turn;
   } cordic_cmd_type;

   typedef struct packed {
      logic done;
      logic signed [31:0] cos_val;
      logic signed [31:0] sin_val;
   } cordic_res_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] t;
      case (idx)
         5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;
         5'd2: t = 32'h09FB385B;  5'd3: t = 32'h051111D4;
         5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
         5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;
         5'd8: t = 32'h0028BE53;  5'd9: t = 32'h00145F2F;
         5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
         5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
         5'd14: t = 32'h0000A2FA; 5'd15: t = 32'h0000517D;
         5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
         5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518;
         5'd20: t = 32'h0000028C; 5'd21: t = 32'h00000146;
         5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
         default: t = 32'h0;
      endcase
      return t;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// File: sv/htu_stream_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface htu_req_if;
   logic valid;
   logic ready;
   logic [2:0] kind;
   logic signed [31:0] operand_x;
   logic signed [31:0] operand_y;
   logic signed [31:0] angle;
   modport source(output valid, kind, operand_x, operand_y, angle, input ready);
   modport sink(input valid, kind, operand_x, operand_y, angle, output ready);
endinterface

interface htu_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   modport source(output valid, out_x, out_y, input ready);
   modport sink(input valid, out_x, out_y, output ready);
endinterface
`default_nettype wire

// File: sv/htu_cordic.sv
// Iterative rotation-mode CORDIC producing cosine and sine of a binary angle.
`default_nettype none
module htu_cordic #(
   parameter int FRAC_BITS = htu_pkg::FRAC_BITS_DEFAULT,
   parameter int CORDIC_STEPS = htu_pkg::CORDIC_STEPS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire htu_pkg::cordic_cmd_type cmd,
   output htu_pkg::cordic_res_type res
);
   import htu_pkg::*;
   localparam int SH = 30 - FRAC_BITS;
   localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

   logic busy_ff, busy_in, flip_ff, flip_in;
   logic [4:0] step_ff, step_in;
   logic signed [35:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic done_ff, done_in;
   logic signed [31:0] c_ff, c_in, s_ff, s_in;
   logic [31:0] tf;
   logic signed [35:0] xr, yr;

   always_comb begin
      busy_in = busy_ff; flip_in = flip_ff; step_in = step_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      done_in = 1'b0; c_in = c_ff; s_in = s_ff;
      tf = cmd.turn;
      xr = '0; yr = '0;
      if (cmd.start) begin
         flip_in = (cmd.turn[31:30] == 2'd1) || (cmd.turn[31:30] == 2'd2);
         if (flip_in) tf = cmd.turn - 32'h80000000;
         z_in = 34'(signed'(tf));
         x_in = 36'(CORDIC_GAIN_Q30);
         y_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff < 5'(STEPS)) begin
            if (!z_ff[33]) begin
               x_in = x_ff - (y_ff >>> step_ff);
               y_in = y_ff + (x_ff >>> step_ff);
               z_in = z_ff - 34'(atan_turn(step_ff));
            end else begin
               x_in = x_ff + (y_ff >>> step_ff);
               y_in = y_ff - (x_ff >>> step_ff);
               z_in = z_ff + 34'(atan_turn(step_ff));
            end
            step_in = step_ff + 5'd1;
         end else begin
            xr = (x_ff + 36'(1 <<< (SH - 1))) >>> SH;
            yr = (y_ff + 36'(1 <<< (SH - 1))) >>> SH;
            if (flip_ff) begin
               xr = -xr; yr = -yr;
            end
            c_in = sat32(64'(xr));
            s_in = sat32(64'(yr));
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      flip_ff <= flip_in; step_ff <= step_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      c_ff <= c_in; s_ff <= s_in;
   end

   assign res.done = done_ff;
   assign res.cos_val = c_ff;
   assign res.sin_val = s_ff;

`ifndef SYNTH
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("cordic done while busy");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= 5'(STEPS)) else $error("cordic step overrun");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("cordic done held");
`endif
endmodule
`default_nettype wire

// File: sv/homogeneous_transform_unit_top.sv
// Top level of the 4x4 homogeneous transform unit.
`default_nettype none
// Holds a 4x4 Q16.16 matrix in two 16-entry synchronous memory banks and runs one
// request at a time; after reset the identity is loaded into all 16 entries
// before the first request is taken. Translate and scale build each of the 16
// new entries from four memory reads through one multiplier, each read passing
// through the read, wait and accumulate states, followed by a write-back state;
// rotations first convert the angle to a binary turn and run the CORDIC.
// Vector requests give one result. An output register holds a finished result so
// that the next request can be accepted while the result waits; a further
// vector result waits in its last state until that register frees.
module homogeneous_transform_unit_top #(
   parameter int FRAC_BITS = htu_pkg::FRAC_BITS_DEFAULT,
   parameter int CORDIC_STEPS = htu_pkg::CORDIC_STEPS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   htu_req_if.sink req,
   htu_rsp_if.source rsp
);
   import htu_pkg::*;
   localparam int CELLS = DIM_DEFAULT * DIM_DEFAULT;
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_TRANS, ST_ANGLE, ST_CORDIC, ST_MUL_RD, ST_MUL_WAIT,
      ST_MUL_ACC, ST_MUL_WB, ST_COPY, ST_VEC, ST_OUT
   } state_type;

   logic signed [31:0] mem_a [CELLS];
   logic signed [31:0] mem_b [CELLS];
   logic bank_ff, bank_in;
   logic [3:0] rd_addr;
   logic signed [31:0] rd_a_ff, rd_b_ff, rd_data;
   logic wr_en;
   logic wr_bank;
   logic [3:0] wr_addr;
   logic signed [31:0] wr_data;

   state_type st_ff, st_in;
   kind_type kind_ff, kind_in;
   logic signed [31:0] ox_ff, ox_in, oy_ff, oy_in, ang_ff, ang_in;
   logic signed [31:0] c_ff, c_in, s_ff, s_in;
   logic [4:0] idx_ff, idx_in;
   logic [2:0] k_ff, k_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] hold_ff, hold_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rx_ff, rx_in, ry_ff, ry_in;
   cordic_cmd_type ccmd;
   cordic_res_type cres;
   logic signed [63:0] tp;
   logic [1:0] r, c;
   logic signed [31:0] rhs;
   logic signed [63:0] pr;

   htu_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .cmd(ccmd), .res(cres));

   assign rd_data = bank_ff ? rd_b_ff : rd_a_ff;
   assign req.ready = (st_ff == ST_IDLE);

   function automatic logic signed [31:0] rhs_entry(input kind_type k,
      input logic [1:0] rr, input logic [1:0] cc, input logic signed [31:0] x,
      input logic signed [31:0] y, input logic signed [31:0] cs,
      input logic signed [31:0] sn, input logic signed [31:0] one);
      logic signed [31:0] v;
      v = (rr == cc) ? one : 32'sd0;
      case (k)
         KIND_TRANSLATE: begin
            if (rr == 2'd0 && cc == 2'd3) v = x;
            if (rr == 2'd1 && cc == 2'd3) v = y;
         end
         KIND_SCALE: begin
            if (rr == 2'd0 && cc == 2'd0) v = x;
            if (rr == 2'd1 && cc == 2'd1) v = y;
         end
         default: begin
            if (rr == 2'd0 && cc == 2'd0) v = cs;
            if (rr == 2'd1 && cc == 2'd1) v = cs;
            if (rr == 2'd0 && cc == 2'd1) v = sat32(-64'(sn));
            if (rr == 2'd1 && cc == 2'd0) v = sn;
         end
      endcase
      return v;
   endfunction

   always_comb begin
      st_in = st_ff; kind_in = kind_ff; ox_in = ox_ff; oy_in = oy_ff; ang_in = ang_ff;
      c_in = c_ff; s_in = s_ff; idx_in = idx_ff; k_in = k_ff; prod_in = prod_ff;
      acc_in = acc_ff; hold_in = hold_ff; bank_in = bank_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready; rx_in = rx_ff; ry_in = ry_ff;
      ccmd = '0; rd_addr = '0; wr_en = 1'b0; wr_bank = bank_ff; wr_addr = '0;
      wr_data = '0; tp = '0;
      r = idx_ff[3:2]; c = idx_ff[1:0];
      rhs = rhs_entry(kind_ff, k_ff[1:0], c, ox_ff, oy_ff, c_ff, s_ff, ONE);
      pr = 64'(rd_data) * 64'(rhs);
      case (st_ff)
         ST_INIT: begin
            wr_en = 1'b1; wr_addr = idx_ff[3:0];
            wr_data = (idx_ff[3:2] == idx_ff[1:0]) ? ONE : 32'sd0;
            idx_in = idx_ff + 5'd1;
            if (idx_ff == 5'(CELLS - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               kind_in = kind_type'(req.kind);
               ox_in = req.operand_x; oy_in = req.operand_y; ang_in = req.angle;
               idx_in = '0; k_in = '0; acc_in = '0;
               case (kind_type'(req.kind))
                  KIND_IDENTITY: st_in = ST_INIT;
                  KIND_TRANSPOSE: st_in = ST_TRANS;
                  KIND_TRANSLATE, KIND_SCALE: st_in = ST_MUL_RD;
                  KIND_ROT_DEG, KIND_ROT_RAD: st_in = ST_ANGLE;
                  KIND_VECTOR: st_in = ST_VEC;
                  default: st_in = ST_IDLE;
               endcase
            end
         end
         ST_TRANS: begin
            // Read element, then write it to the mirrored place in the other bank.
            rd_addr = {idx_ff[1:0], idx_ff[3:2]};
            if (k_ff[0]) begin
               wr_en = 1'b1; wr_bank = !bank_ff; wr_addr = idx_ff[3:0]; wr_data = rd_data;
               k_in = 3'd0; idx_in = idx_ff + 5'd1;
               if (idx_ff == 5'(CELLS - 1)) begin
                  bank_in = !bank_ff; st_in = ST_IDLE;
               end
            end else k_in = 3'd1;
         end
         ST_ANGLE: begin
            if (kind_ff == KIND_ROT_DEG)
               tp = (64'(ang_ff) * 64'(signed'({1'b0, DEG_TO_TURN})) +
                     (64'sd1 <<< (FRAC_BITS + 7))) >>> (FRAC_BITS + 8);
            else
               tp = (64'(ang_ff) * 64'(signed'({1'b0, RAD_TO_TURN})) +
                     (64'sd1 <<< (FRAC_BITS + 1))) >>> (FRAC_BITS + 2);
            ccmd.start = 1'b1; ccmd.turn = tp[31:0];
            st_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            if (cres.done) begin
               c_in = cres.cos_val; s_in = cres.sin_val; st_in = ST_MUL_RD;
            end
         end
         ST_MUL_RD: begin
            rd_addr = {r, k_ff[1:0]}; st_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            prod_in = pr; st_in = ST_MUL_ACC;
         end
         ST_MUL_ACC: begin
            acc_in = acc_ff + ((prod_ff + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
            if (k_ff == 3'd3) st_in = ST_MUL_WB;
            else begin
               k_in = k_ff + 3'd1; st_in = ST_MUL_RD;
            end
         end
         ST_MUL_WB: begin
            wr_en = 1'b1; wr_bank = !bank_ff; wr_addr = idx_ff[3:0];
            wr_data = sat32(acc_ff);
            acc_in = '0; k_in = '0; idx_in = idx_ff + 5'd1;
            if (idx_ff == 5'(CELLS - 1)) begin
               bank_in = !bank_ff; st_in = ST_IDLE;
            end else st_in = ST_MUL_RD;
         end
         ST_VEC: begin
            // k: 0..2 read m[r][0], m[r][1], m[r][3]; each registered value is used at the next k.
            rd_addr = {idx_ff[1:0], (k_ff == 3'd2) ? 2'd3 : k_ff[1:0]};
            if (k_ff != 3'd0) begin
               if (k_ff == 3'd3)
                  acc_in = acc_ff + 64'(rd_data);
               else
                  acc_in = acc_ff + (((64'(rd_data) *
                     64'((k_ff == 3'd1) ? ox_ff : oy_ff)) +
                     (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
            end
            if (k_ff == 3'd3) begin
               if (idx_ff[0]) begin
                  st_in = ST_OUT;
               end else begin
                  hold_in = sat32(acc_in); idx_in = 5'd1; k_in = '0; acc_in = '0;
               end
            end else k_in = k_ff + 3'd1;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rx_in = hold_ff; ry_in = sat32(acc_ff);
               rsp_valid_in = 1'b1; st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en && !wr_bank) mem_a[wr_addr] <= wr_data;
      if (wr_en && wr_bank) mem_b[wr_addr] <= wr_data;
      rd_a_ff <= mem_a[rd_addr];
      rd_b_ff <= mem_b[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_INIT; idx_ff <= '0; bank_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         st_ff <= st_in; idx_ff <= idx_in; bank_ff <= bank_in; rsp_valid_ff <= rsp_valid_in;
         k_ff <= k_in;
      end
      kind_ff <= kind_in; ox_ff <= ox_in; oy_ff <= oy_in; ang_ff <= ang_in;
      c_ff <= c_in; s_ff <= s_in; prod_ff <= prod_in;
      acc_ff <= acc_in; hold_ff <= hold_in; rx_ff <= rx_in; ry_ff <= ry_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.out_x = rx_ff;
   assign rsp.out_y = ry_ff;

`ifndef SYNTH
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> st_ff == ST_IDLE) else $error("ready outside idle");
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_ff) == ST_OUT) else $error("stray result");
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= 3'd3) else $error("tap counter overrun");
`endif
endmodule
`default_nettype wire
